// ===== design/afc_dac_integrator_top_macros.svh =====
// assertion macros for the afc dac integrator
`ifndef AFC_DAC_INTEGRATOR_TOP_MACROS_SVH
`define AFC_DAC_INTEGRATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define AFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFC_ASSERT(lbl, prop, msg)
`define AFC_ASSERT_IMP(lbl, ante, cons, msg)
`define AFC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/afc_pkg.sv =====
// shared types and constants of the afc dac integrator
`timescale 1ns / 1ps
`default_nettype none
package afc_pkg;

    localparam int ERR_W     = 24;
    localparam int TIME_W    = 30;
    localparam int DAC_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 24;
    localparam int THR_W     = 16;
    localparam int COEF_W    = 24;
    localparam int OFF_W     = 35;
    localparam int PROD_W    = ERR_W + COEF_W + 1;
    localparam int SUM_W     = PROD_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL_MS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN            = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_STEP      = 8'd4;

    localparam logic [THR_W-1:0]  DEAD_ZONE_RST    = 16'd75;
    localparam logic [THR_W-1:0]  LARGE_THR_RST    = 16'd350;
    localparam logic [THR_W-1:0]  MIN_INTERVAL_RST = 16'd250;
    localparam logic [COEF_W-1:0] GAIN_RST         = 24'd94489;
    localparam logic [COEF_W-1:0] SMALL_STEP_RST   = 24'd1048576;

    localparam logic signed [OFF_W-1:0] OFFSET_RST = 35'sd1395864371;
    localparam logic signed [SUM_W-1:0] OFFSET_MAX = 50'sd8589934591;
    localparam logic signed [SUM_W-1:0] OFFSET_MIN = -50'sd8589934592;

    localparam logic [DAC_W-1:0] DAC_MASK = 16'hfffc;
    localparam logic [DAC_W-1:0] DAC_FULL = 16'hffff;

    typedef struct packed {
        logic load;
        logic eval;
        logic acc;
        logic dac;
    } afc_cmd_t;

    typedef struct packed {
        logic fire;
    } afc_sts_t;

endpackage
`default_nettype wire

// ===== design/afc_dac_integrator_top.sv =====
// top level of the afc dac integrator
`timescale 1ns / 1ps
`default_nettype none
// Frequency-control integrator for a 16-bit oscillator DAC. Each input beat
// carries a signed frequency error and the millisecond time; when enough
// time has passed and the error lies outside the dead zone the Q2.32 offset
// is moved and one beat with the new DAC word leaves, otherwise nothing
// leaves. An updating item goes through capture, decision and multiply,
// accumulate and DAC word; others end after the decision. The controller
// works on one item at a time and the output register lets the next item
// in while a DAC word still waits. Configuration must be written through
// the cfg port while the block is idle; the block does not enforce this.
`include "afc_dac_integrator_top_macros.svh"
module afc_dac_integrator_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [afc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [afc_pkg::ERR_W-1:0]  freq_error,
    input  wire logic [afc_pkg::TIME_W-1:0]        now_ms,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [afc_pkg::DAC_W-1:0]              dac_value
);
    import afc_pkg::*;

    afc_cmd_t cmd;
    afc_sts_t sts;

    afc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    afc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .freq_error (freq_error),
        .now_ms     (now_ms),
        .dac_value  (dac_value),
        .cmd        (cmd),
        .sts        (sts)
    );

    `AFC_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.eval, cmd.acc, cmd.dac}), "commands overlap")
    `AFC_ASSERT_NXT(a_busy_after_load, cmd.load, in_stall, "input not stalled after beat")
    `AFC_ASSERT_NXT(a_valid_after_dac, cmd.dac, out_valid, "dac word not presented")
    `AFC_ASSERT_IMP(a_dac_low_bits, out_valid, dac_value[1:0] == 2'b00, "dac low bits set")

endmodule
`default_nettype wire

// ===== design/afc_ctrl.sv =====
// sequencer of the afc dac integrator
`timescale 1ns / 1ps
`default_nettype none
module afc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire afc_pkg::afc_sts_t sts,
    output afc_pkg::afc_cmd_t      cmd
);
    import afc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_ACC,
        S_DAC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_valid;
        cmd.eval = (state_reg == S_EVAL);
        cmd.acc  = (state_reg == S_ACC);
        cmd.dac  = (state_reg == S_DAC) && (!out_valid_reg || !out_stall);
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.dac)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    state_reg <= sts.fire ? S_ACC : S_IDLE;
                end
                S_ACC:
                begin
                    state_reg <= S_DAC;
                end
                S_DAC:
                begin
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/afc_dp.sv =====
// datapath of the afc dac integrator: config, timestamp, offset and dac word
`timescale 1ns / 1ps
`default_nettype none
module afc_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [afc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic signed [afc_pkg::ERR_W-1:0]  freq_error,
    input  wire logic [afc_pkg::TIME_W-1:0]        now_ms,
    output logic [afc_pkg::DAC_W-1:0]              dac_value,
    input  wire afc_pkg::afc_cmd_t                 cmd,
    output afc_pkg::afc_sts_t                      sts
);
    import afc_pkg::*;

    logic [THR_W-1:0]  dead_zone_reg;
    logic [THR_W-1:0]  large_thr_reg;
    logic [THR_W-1:0]  min_interval_reg;
    logic [COEF_W-1:0] gain_reg;
    logic [COEF_W-1:0] small_step_reg;

    logic [TIME_W-1:0]       last_time_reg;
    logic signed [OFF_W-1:0] offset_reg;

    logic signed [ERR_W-1:0]  err_reg;
    logic [ERR_W-1:0]         mag_reg;
    logic [TIME_W:0]          elapsed_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DAC_W-1:0]         dac_reg;

    logic [ERR_W-1:0]         mag_next;
    logic [TIME_W:0]          elapsed_next;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prop_step;
    logic                     err_pos;
    logic signed [SUM_W-1:0]  off_ext;
    logic signed [SUM_W-1:0]  step_ext;
    logic signed [SUM_W-1:0]  sum;
    logic signed [OFF_W-1:0]  offset_next;
    logic [OFF_W+DAC_W-3:0]   scaled;
    logic [DAC_W:0]           dac_hi;
    logic [DAC_W-1:0]         dac_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg    <= DEAD_ZONE_RST;
            large_thr_reg    <= LARGE_THR_RST;
            min_interval_reg <= MIN_INTERVAL_RST;
            gain_reg         <= GAIN_RST;
            small_step_reg   <= SMALL_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE:       dead_zone_reg    <= cfg_data[THR_W-1:0];
                CFG_LARGE_THRESHOLD: large_thr_reg    <= cfg_data[THR_W-1:0];
                CFG_MIN_INTERVAL_MS: min_interval_reg <= cfg_data[THR_W-1:0];
                CFG_GAIN:            gain_reg         <= cfg_data[COEF_W-1:0];
                CFG_SMALL_STEP:      small_step_reg   <= cfg_data[COEF_W-1:0];
                default:             ;
            endcase
        end
    end

    // input beat capture
    assign mag_next     = freq_error[ERR_W-1] ? (~freq_error + ERR_W'(1)) : freq_error;
    assign elapsed_next = {1'b0, now_ms} - {1'b0, last_time_reg};

    // update decision and proportional product
    assign sts.fire = !elapsed_reg[TIME_W]
                   && (elapsed_reg[TIME_W-1:0] > {{(TIME_W-THR_W){1'b0}}, min_interval_reg})
                   && (mag_reg > {{(ERR_W-THR_W){1'b0}}, dead_zone_reg});
    assign prod_next = err_reg * $signed({1'b0, gain_reg});

    // accumulate and saturate
    assign prop_step = mag_reg > {{(ERR_W-THR_W){1'b0}}, large_thr_reg};
    assign err_pos   = !err_reg[ERR_W-1] && (|err_reg);
    assign off_ext   = {{(SUM_W-OFF_W){offset_reg[OFF_W-1]}}, offset_reg};
    assign step_ext  = {{(SUM_W-COEF_W){1'b0}}, small_step_reg};

    always_comb
    begin
        if (prop_step)
            sum = off_ext - {prod_reg[PROD_W-1], prod_reg};
        else if (err_pos)
            sum = off_ext - step_ext;
        else
            sum = off_ext + step_ext;

        if (sum > OFFSET_MAX)
            offset_next = OFFSET_MAX[OFF_W-1:0];
        else if (sum < OFFSET_MIN)
            offset_next = OFFSET_MIN[OFF_W-1:0];
        else
            offset_next = sum[OFF_W-1:0];
    end

    // dac word: offset * 65535 / 2^32, clamped and masked
    assign scaled = {offset_reg[OFF_W-3:0], {DAC_W{1'b0}}}
                  - {{DAC_W{1'b0}}, offset_reg[OFF_W-3:0]};
    assign dac_hi = scaled[OFF_W+DAC_W-3:OFF_W+DAC_W-3-DAC_W];

    always_comb
    begin
        if (offset_reg[OFF_W-1])
            dac_next = '0;
        else if (dac_hi[DAC_W])
            dac_next = DAC_FULL & DAC_MASK;
        else
            dac_next = dac_hi[DAC_W-1:0] & DAC_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            offset_reg    <= OFFSET_RST;
        end
        else
        begin
            if (cmd.load)
                last_time_reg <= now_ms;
            if (cmd.acc)
                offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg     <= freq_error;
            mag_reg     <= mag_next;
            elapsed_reg <= elapsed_next;
        end
        if (cmd.eval)
            prod_reg <= prod_next;
        if (cmd.dac)
            dac_reg <= dac_next;
    end

    assign dac_value = dac_reg;

endmodule
`default_nettype wire
